@@ design/okm_pkg.sv @@
// Shared constants and the state type of the online k-means block.
// No dependencies; every other file of the block but okm_ram imports this package.
package okm_pkg;

  // Storage sizes
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIMS     = 8;
  localparam int COORD_WIDTH  = 16;

  // Configuration port
  localparam int CFG_W       = 4;
  localparam int LR_W        = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGETFUL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd3;
  localparam logic [CFG_W-1:0]     RST_NUM_CLUSTERS = 4'd3;
  localparam logic [CFG_W-1:0]     RST_NUM_DIMS     = 4'd3;
  localparam logic [LR_W-1:0]      RST_LEARN_RATE   = 16'd13107;

  // Derived widths
  localparam int OUT_CL_W = 3;
  localparam int CL_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DI_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int K_W      = $clog2(MAX_CLUSTERS + 1);
  localparam int D_W      = $clog2(MAX_DIMS + 1);
  localparam int DEPTH    = MAX_CLUSTERS * MAX_DIMS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = 16;
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int MUL_W    = (DIFF_W > LR_W + 1) ? DIFF_W : LR_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 2 * COORD_WIDTH + $clog2(MAX_DIMS + 1);
  localparam int DIVN_W   = ((COORD_WIDTH > CNT_W) ? COORD_WIDTH : CNT_W) + 2;
  localparam int DIVD_W   = CNT_W + 2;
  localparam int DELTA_W  = (DIVN_W + 1 > PROD_W - LR_W + 1) ? DIVN_W + 1
                                                              : PROD_W - LR_W + 1;
  localparam int NEW_W    = DELTA_W + 1;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SEED  = 13'b0000000000010,
    S_DRD   = 13'b0000000000100,
    S_DSUB  = 13'b0000000001000,
    S_DMUL  = 13'b0000000010000,
    S_DACC  = 13'b0000000100000,
    S_URD   = 13'b0000001000000,
    S_USUB  = 13'b0000010000000,
    S_UMUL  = 13'b0000100000000,
    S_UDIV  = 13'b0001000000000,
    S_UWAIT = 13'b0010000000000,
    S_UWR   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // Divider result
  typedef struct packed {
    logic              done;
    logic              rem_nz;
    logic [DIVN_W-1:0] quot;
  } div_res_t;

endpackage

@@ design/online_kmeans_cluster_update.sv @@
// Online k-means: one coordinate per item; a point completes after num_dims items.
// A completing item either seeds a new centroid from the buffered point or runs a
// distance pass (one shared multiplier, RAM read, accumulate) and then an update per
// dimension, forgetful or running mean (18-step divider), before its result is posted.
// Non-completing items are only buffered. Reset (synchronous, rst_n low) clears
// control state, member counts and configuration registers; centroids stay undefined.
module online_kmeans_cluster_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [okm_pkg::COORD_WIDTH-1:0] in_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [okm_pkg::OUT_CL_W-1:0]        out_cluster,
  output logic                                out_seeded,
  input  logic                                cfg_we,
  input  logic [okm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [okm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import okm_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] num_clusters_r;
  logic [CFG_W-1:0] num_dims_r;
  logic             forgetful_r;
  logic [LR_W-1:0]  learn_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= RST_NUM_CLUSTERS;
      num_dims_r     <= RST_NUM_DIMS;
      forgetful_r    <= 1'b0;
      learn_rate_r   <= RST_LEARN_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters_r <= cfg_wdata[CFG_W-1:0];
        CFG_NUM_DIMS:     num_dims_r     <= cfg_wdata[CFG_W-1:0];
        CFG_FORGETFUL:    forgetful_r    <= cfg_wdata[0];
        CFG_LEARN_RATE:   learn_rate_r   <= cfg_wdata[LR_W-1:0];
      endcase
    end
  end

  // Clamp counts into range
  logic [K_W-1:0] k_eff;
  logic [D_W-1:0] d_eff;
  always_comb begin
    if (num_clusters_r == '0) begin
      k_eff = K_W'(1);
    end else if (int'(num_clusters_r) > MAX_CLUSTERS) begin
      k_eff = K_W'(MAX_CLUSTERS);
    end else begin
      k_eff = K_W'(num_clusters_r);
    end
    if (num_dims_r == '0) begin
      d_eff = D_W'(1);
    end else if (int'(num_dims_r) > MAX_DIMS) begin
      d_eff = D_W'(MAX_DIMS);
    end else begin
      d_eff = D_W'(num_dims_r);
    end
  end

  // State
  state_t                          state_r, state_nxt;
  logic [DI_W-1:0]                 idx_r, idx_nxt;
  logic [K_W-1:0]                  seeded_r, seeded_nxt;
  logic [K_W-1:0]                  k_r, k_nxt;
  logic [D_W-1:0]                  dims_r, dims_nxt;
  logic [CL_W-1:0]                 c_r, c_nxt;
  logic [DI_W-1:0]                 d_r, d_nxt;
  logic [CL_W-1:0]                 best_cl_r, best_cl_nxt;
  logic [ACC_W-1:0]                acc_r, acc_nxt;
  logic [ACC_W-1:0]                best_r, best_nxt;
  logic signed [DIFF_W-1:0]        diff_r, diff_nxt;
  logic signed [COORD_WIDTH-1:0]   cval_r, cval_nxt;
  logic signed [PROD_W-1:0]        prod_r, prod_nxt;
  logic                            neg_r, neg_nxt;
  logic                            seed_r, seed_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [OUT_CL_W-1:0]             out_cluster_r, out_cluster_nxt;
  logic                            out_seeded_r, out_seeded_nxt;
  logic signed [COORD_WIDTH-1:0]   pbuf_r [MAX_DIMS];
  logic [CNT_W-1:0]                cnt_r [MAX_CLUSTERS];

  // Centroid store
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [COORD_WIDTH-1:0] ram_wdata;
  logic [COORD_WIDTH-1:0] ram_rdata;

  assign ram_addr = ADDR_W'(ADDR_W'(c_r) * ADDR_W'(MAX_DIMS) + ADDR_W'(d_r));

  okm_ram #(.WIDTH(COORD_WIDTH), .DEPTH(DEPTH)) u_cent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;
  assign mul_a = MUL_W'(diff_r);
  assign mul_b = (state_r == S_UMUL) ? signed'({(MUL_W-LR_W)'(0), learn_rate_r})
                                     : MUL_W'(diff_r);

  // Divider for the running-mean step
  logic                      div_start;
  logic [CNT_W:0]            n_val;
  logic signed [DIVN_W:0]    num_s;
  logic [DIVN_W-1:0]         num_mag;
  logic [DIVD_W-1:0]         den;
  div_res_t                  div_res;

  assign n_val   = {1'b0, cnt_r[c_r]} + 1'b1;
  assign num_s   = ((DIVN_W+1)'(diff_r) <<< 1) + signed'((DIVN_W+1)'(n_val));
  assign num_mag = DIVN_W'(num_s[DIVN_W] ? -num_s : num_s);
  assign den     = DIVD_W'({n_val, 1'b0});

  okm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den),
    .res      (div_res)
  );

  // Centroid step and saturation
  logic signed [PROD_W:0]    rnd;
  logic signed [DELTA_W-1:0] delta_f, delta_m, delta;
  logic signed [DELTA_W-1:0] q_s;
  logic signed [NEW_W-1:0]   new_full;
  logic signed [COORD_WIDTH-1:0] new_sat;
  localparam logic signed [NEW_W-1:0] C_MAX = NEW_W'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
  localparam logic signed [NEW_W-1:0] C_MIN = -C_MAX - NEW_W'(1);

  always_comb begin
    rnd     = (PROD_W+1)'(prod_r) + (PROD_W+1)'(64'sd1 <<< (LR_W-1));
    delta_f = DELTA_W'(rnd >>> LR_W);
    q_s     = signed'(DELTA_W'(div_res.quot));
    delta_m = neg_r ? (-q_s - DELTA_W'(div_res.rem_nz)) : q_s;
    delta   = forgetful_r ? delta_f : delta_m;
    new_full = NEW_W'(cval_r) + NEW_W'(delta);
    if (new_full > C_MAX) begin
      new_sat = COORD_WIDTH'(C_MAX);
    end else if (new_full < C_MIN) begin
      new_sat = COORD_WIDTH'(C_MIN);
    end else begin
      new_sat = COORD_WIDTH'(new_full);
    end
  end

  // Sequencer
  logic [D_W-1:0]   idx_inc;
  logic             last_d, last_c;
  logic [ACC_W-1:0] acc_sum;

  assign idx_inc = D_W'(idx_r) + 1'b1;
  assign last_d  = (d_r == DI_W'(dims_r - 1'b1));
  assign last_c  = (c_r == CL_W'(k_r - 1'b1));
  assign acc_sum = acc_r + ACC_W'($unsigned(prod_r));

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    seeded_nxt      = seeded_r;
    k_nxt           = k_r;
    dims_nxt        = dims_r;
    c_nxt           = c_r;
    d_nxt           = d_r;
    best_cl_nxt     = best_cl_r;
    acc_nxt         = acc_r;
    best_nxt        = best_r;
    diff_nxt        = diff_r;
    cval_nxt        = cval_r;
    prod_nxt        = prod_r;
    neg_nxt         = neg_r;
    seed_nxt        = seed_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_cluster_nxt = out_cluster_r;
    out_seeded_nxt  = out_seeded_r;
    ram_we          = 1'b0;
    ram_wdata       = new_sat;
    div_start       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (idx_inc < d_eff) begin
            idx_nxt = DI_W'(idx_inc);
          end else begin
            // Point complete: seed or classify
            idx_nxt  = '0;
            k_nxt    = k_eff;
            dims_nxt = d_eff;
            d_nxt    = '0;
            acc_nxt  = '0;
            if (seeded_r < k_eff) begin
              c_nxt     = CL_W'(seeded_r);
              seed_nxt  = 1'b1;
              state_nxt = S_SEED;
            end else begin
              c_nxt     = '0;
              seed_nxt  = 1'b0;
              state_nxt = S_DRD;
            end
          end
        end
      end
      S_SEED: begin
        ram_we    = 1'b1;
        ram_wdata = pbuf_r[d_r];
        d_nxt     = d_r + 1'b1;
        if (last_d) begin
          seeded_nxt = seeded_r + 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DRD: begin
        state_nxt = S_DSUB;
      end
      S_DSUB: begin
        diff_nxt  = DIFF_W'(pbuf_r[d_r]) - DIFF_W'(signed'(ram_rdata));
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        acc_nxt   = acc_sum;
        d_nxt     = d_r + 1'b1;
        state_nxt = S_DRD;
        if (last_d) begin
          // Keep the strictly nearer cluster
          acc_nxt = '0;
          d_nxt   = '0;
          if (c_r == '0 || acc_sum < best_r) begin
            best_nxt    = acc_sum;
            best_cl_nxt = c_r;
          end
          if (last_c) begin
            c_nxt     = (c_r == '0 || acc_sum < best_r) ? c_r : best_cl_r;
            state_nxt = S_URD;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_URD: begin
        state_nxt = S_USUB;
      end
      S_USUB: begin
        cval_nxt  = signed'(ram_rdata);
        diff_nxt  = DIFF_W'(pbuf_r[d_r]) - DIFF_W'(signed'(ram_rdata));
        state_nxt = forgetful_r ? S_UMUL : S_UDIV;
      end
      S_UMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_UWR;
      end
      S_UDIV: begin
        div_start = 1'b1;
        neg_nxt   = num_s[DIVN_W];
        state_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        if (div_res.done) begin
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        ram_we    = 1'b1;
        d_nxt     = d_r + 1'b1;
        state_nxt = last_d ? S_DONE : S_URD;
      end
      S_DONE: begin
        // Hold until the result slot is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_cluster_nxt = OUT_CL_W'(c_r);
          out_seeded_nxt  = seed_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      seeded_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      // Advance the member count of the chosen cluster, saturating
      if (state_r == S_DONE && state_nxt == S_IDLE && cnt_r[c_r] != '1) begin
        cnt_r[c_r] <= cnt_r[c_r] + 1'b1;
      end
    end
    k_r           <= k_nxt;
    dims_r        <= dims_nxt;
    c_r           <= c_nxt;
    d_r           <= d_nxt;
    best_cl_r     <= best_cl_nxt;
    acc_r         <= acc_nxt;
    best_r        <= best_nxt;
    diff_r        <= diff_nxt;
    cval_r        <= cval_nxt;
    prod_r        <= prod_nxt;
    neg_r         <= neg_nxt;
    seed_r        <= seed_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_seeded_r  <= out_seeded_nxt;
    // Capture the coordinate of an accepted item
    if (state_r == S_IDLE && in_valid) begin
      pbuf_r[idx_r] <= in_coord;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_cluster = out_cluster_r;
  assign out_seeded  = out_seeded_r;

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");
  a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(seeded_r) <= MAX_CLUSTERS)
    else $error("seeded count beyond cluster storage");
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_UWAIT)
    else $error("divider finished outside its wait step");
`endif

endmodule

@@ design/okm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the centroid store.
module okm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/okm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on okm_pkg for widths and the result struct.
module okm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [okm_pkg::DIVN_W-1:0] dividend,
  input  logic [okm_pkg::DIVD_W-1:0] divisor,
  output okm_pkg::div_res_t         res
);
  import okm_pkg::*;

  localparam int STEP_W = $clog2(DIVN_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIVN_W-1:0] quot_r, quot_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] den_r, den_nxt;
  logic [DIVD_W:0]   trial;

  // One restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quot_r[DIVN_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = DIVD_W'(trial - {1'b0, den_r});
        quot_nxt = {quot_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_nxt  = DIVD_W'(trial);
        quot_nxt = {quot_r[DIVN_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIVN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign res.done   = done_r;
  assign res.rem_nz = |rem_r;
  assign res.quot   = quot_r;

endmodule

@@ dv/tb.sv @@
// Testbench for the online k-means cluster update block: drives coordinates,
// predicts each point's cluster assignment and checks every result item.
// Depends on okm_pkg and online_kmeans_cluster_update from the design folder.
`timescale 1ns / 100ps

module tb;
  import okm_pkg::*;

  // Tracks centroids, counts and configuration; predicts each assignment
  class cluster_scoreboard;
    typedef struct {
      bit [2:0] cl;
      bit       sd;
    } assign_t;

    logic signed [15:0] cent[8][8];
    logic signed [15:0] pbuf[8];
    bit [15:0]          members[8];
    int unsigned        seeds;
    int unsigned        pos;
    int unsigned        k_cfg;
    int unsigned        d_cfg;
    bit                 forget;
    bit [15:0]          rate;
    assign_t            expected[$];
    int                 errors;
    int                 results;

    function new();
      foreach (members[i]) members[i] = 0;
      seeds = 0;
      pos = 0;
      k_cfg = RST_NUM_CLUSTERS;
      d_cfg = RST_NUM_DIMS;
      forget = 0;
      rate = RST_LEARN_RATE;
      errors = 0;
      results = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_NUM_CLUSTERS: k_cfg = val[3:0];
        CFG_NUM_DIMS:     d_cfg = val[3:0];
        CFG_FORGETFUL:    forget = val[0];
        CFG_LEARN_RATE:   rate = val;
        default: ;
      endcase
    endfunction

    // Take one coordinate; queue an assignment when the point completes
    function void note_coord(logic signed [15:0] v);
      int unsigned        k;
      int unsigned        dims;
      int unsigned        cl;
      bit                 sd;
      longint unsigned    best;
      longint unsigned    acc;
      longint             diff;
      longint             delta;
      longint             num;
      longint             den;
      longint             nv;
      assign_t            a;
      k = (k_cfg == 0) ? 1 : (k_cfg > 8 ? 8 : k_cfg);
      dims = (d_cfg == 0) ? 1 : (d_cfg > 8 ? 8 : d_cfg);
      pbuf[pos % 8] = v;
      pos = pos % 8 + 1;
      if (pos < dims) return;
      pos = 0;
      if (seeds < k) begin
        cl = seeds;
        for (int d = 0; d < dims; d++) cent[cl][d] = pbuf[d];
        seeds++;
        sd = 1;
      end else begin
        cl = 0;
        best = 0;
        // nearest centroid, ties to the lowest index
        for (int c = 0; c < k; c++) begin
          acc = 0;
          for (int d = 0; d < dims; d++) begin
            diff = longint'(pbuf[d]) - longint'(cent[c][d]);
            acc += longint'(diff * diff);
          end
          if (c == 0 || acc < best) begin
            best = acc;
            cl = c;
          end
        end
        // move the winner toward the point
        for (int d = 0; d < dims; d++) begin
          diff = longint'(pbuf[d]) - longint'(cent[cl][d]);
          if (forget) begin
            delta = (longint'(rate) * diff + 32768) >>> 16;
          end else begin
            den = 2 * (longint'(members[cl]) + 1);
            num = 2 * diff + longint'(members[cl]) + 1;
            delta = num / den;
            if (num % den != 0 && num < 0) delta--;
          end
          nv = longint'(cent[cl][d]) + delta;
          if (nv > 32767) nv = 32767;
          if (nv < -32768) nv = -32768;
          cent[cl][d] = nv[15:0];
        end
        sd = 0;
      end
      if (members[cl] != 16'hFFFF) members[cl]++;
      a.cl = cl[2:0];
      a.sd = sd;
      expected.push_back(a);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic [2:0] cl, logic sd);
      assign_t a;
      results++;
      if (expected.size() == 0) begin
        report($sformatf("result cluster=%0d seeded=%0d with nothing pending", cl, sd));
        return;
      end
      a = expected.pop_front();
      if (cl !== a.cl) report($sformatf("cluster got %0d want %0d", cl, a.cl));
      if (sd !== a.sd) report($sformatf("seeded got %0d want %0d", sd, a.sd));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_ready;
  logic signed [COORD_WIDTH-1:0] in_coord = '0;
  logic                        out_valid;
  logic                        out_ready = 0;
  logic [OUT_CL_W-1:0]         out_cluster;
  logic                        out_seeded;
  logic                        cfg_we = 0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_NUM_CLUSTERS;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  cluster_scoreboard sb = new();
  int  send_idle = 0;
  int  recv_idle = 0;
  logic hold_req = 0;
  logic hold_prev = 0;
  int  hold_left = 0;
  int  cycles = 0;
  int  coords_sent = 0;
  int  holds = 0;

  online_kmeans_cluster_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_coord(in_coord),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cluster(out_cluster), .out_seeded(out_seeded),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on each toggle of the request
  always @(posedge clk) begin
    hold_prev <= hold_req;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else if (hold_req != hold_prev) begin
      hold_left <= 400;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: check results before noting the item taken at the same edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_cluster, out_seeded);
    if (rst_n && in_valid && in_ready) sb.note_coord(in_coord);
  end

  task automatic send_coord(input logic [15:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    in_coord <= v;
    coords_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_point(input int n, input logic [15:0] v);
    repeat (n) send_coord(v);
  endtask

  // Stop offering, let every expected item arrive, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (sb.expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers, then release the write enable
  task automatic configure(input int k, input int d, input bit f, input int lr);
    logic [15:0] vals[4];
    logic [CFG_IDX_W-1:0] idx[4];
    vals = '{k[15:0], d[15:0], {15'd0, f}, lr[15:0]};
    idx = '{CFG_NUM_CLUSTERS, CFG_NUM_DIMS, CFG_FORGETFUL, CFG_LEARN_RATE};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_cfg(idx[i], vals[i]);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] pick_coord();
    logic [15:0] bases[4] = '{16'h0100, 16'hF000, 16'h3A00, 16'hC5C0};
    if ($urandom_range(1)) return 16'($urandom_range(65535));
    return bases[$urandom_range(3)] + 16'($urandom_range(0, 255)) - 16'd128;
  endfunction

  task automatic random_phase(input int n);
    int lr;
    case ($urandom_range(3))
      0: lr = 0;
      1: lr = 65535;
      default: lr = $urandom_range(65535);
    endcase
    configure($urandom_range(15), $urandom_range(15), 1'($urandom_range(1)), lr);
    for (int i = 0; i < n; i++) begin
      // long receiver hold-off while items keep coming
      if (i == 20 || $urandom_range(99) == 0) begin
        hold_req <= ~hold_req;
        holds++;
        send_coord(pick_coord());
      end else if ($urandom_range(119) == 0) begin
        in_valid <= 0;
        @(posedge clk);
        while (sb.expected.size() > 0) @(posedge clk);
        send_coord(pick_coord());
      end else begin
        send_coord(pick_coord());
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Seed two extreme centroids with full-size points
    configure(2, 8, 0, 13107);
    send_point(8, 16'h7FFF);
    send_point(8, 16'h8000);
    drain();
    // Raise the cluster count: the next points seed the new clusters
    configure(8, 8, 1, 65535);
    send_point(8, 16'h0000);
    send_point(8, 16'h0000);
    for (int c = 0; c < 4; c++) send_point(8, 16'(16'h1000 * (c + 1) + 16'h0155));
    // Equal distance to two identical centroids goes to the lower index
    send_point(8, 16'h0000);
    drain();
    // Lower the dimension count in the middle of a point
    configure(8, 8, 0, 0);
    send_point(5, 16'h7FFF);
    drain();
    configure(0, 3, 0, 0);
    send_coord(16'h8000);
    drain();
    // Out-of-range counts clamp; zero learning rate leaves centroids in place
    configure(15, 15, 1, 0);
    send_point(8, 16'h8000);
    drain();
    configure(8, 0, 0, 1);
    send_point(3, 16'h7FFF);
    drain();

    // Random phases under three idling patterns
    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 15 : (m == 1 ? 79 : 0);
      recv_idle = (m == 0) ? 79 : (m == 1 ? 15 : 0);
      for (int p = 0; p < 3; p++) random_phase(150);
    end

    // Running-mean updates on a single one-dimensional cluster at the extremes
    send_idle = 0;
    recv_idle = 0;
    configure(1, 1, 0, 30000);
    send_coord(16'h7FFF);
    send_coord(16'h8000);
    send_coord(16'h1234);
    drain();

    if (sb.expected.size() > 0)
      sb.report($sformatf("%0d expected items never arrived", sb.expected.size()));
    $display("covered %0d coordinates, %0d results, %0d receiver hold-offs,",
             coords_sent, sb.results, holds);
    $display("seeding, ties, clamped counts, mid-point resize and both update modes");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/okm_pkg.sv
design/okm_ram.sv
design/okm_div.sv
design/online_kmeans_cluster_update.sv
dv/tb.sv
